// ===== hw/rtl/pbe_pkg.sv =====
// shared types, constants and round functions for the present block encrypt design
`default_nettype none
package pbe_pkg;

    localparam int BLOCK_W        = 64;
    localparam int KEY_DEPTH      = 32;
    localparam int KEY_AW         = 5;
    localparam int ROUNDS_DEFAULT = 31;
    localparam int QUEUE_DEPTH    = 2;

    // operation codes
    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_ENCRYPT = 1'b1;

    typedef logic [BLOCK_W-1:0] block_t;

    // one classified item: data carries the key for a load, the plaintext for an encrypt
    typedef struct packed {
        logic              op;
        logic [KEY_AW-1:0] index;
        block_t            data;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef struct packed {
        logic pop;
        logic busy;
    } bk_ctrl_t;

    function automatic logic [3:0] sbox4(input logic [3:0] x);
        logic [3:0] y;
        case (x)
            4'h0: y = 4'hC;
            4'h1: y = 4'h5;
            4'h2: y = 4'h6;
            4'h3: y = 4'hB;
            4'h4: y = 4'h9;
            4'h5: y = 4'h0;
            4'h6: y = 4'hA;
            4'h7: y = 4'hD;
            4'h8: y = 4'h3;
            4'h9: y = 4'hE;
            4'hA: y = 4'hF;
            4'hB: y = 4'h8;
            4'hC: y = 4'h4;
            4'hD: y = 4'h7;
            4'hE: y = 4'h1;
            4'hF: y = 4'h2;
            default: y = 4'h0;
        endcase
        return y;
    endfunction

    function automatic block_t sub_layer(input block_t s);
        block_t r;
        for (int n = 0; n < BLOCK_W / 4; n++)
        begin
            r[4*n +: 4] = sbox4(s[4*n +: 4]);
        end
        return r;
    endfunction

    // bit i moves to (16*i) mod 63, top bit stays
    function automatic block_t perm_layer(input block_t s);
        block_t r;
        for (int i = 0; i < BLOCK_W - 1; i++)
        begin
            r[(i * 16) % (BLOCK_W - 1)] = s[i];
        end
        r[BLOCK_W-1] = s[BLOCK_W-1];
        return r;
    endfunction

    function automatic block_t round_fn(input block_t s, input block_t rk);
        return perm_layer(sub_layer(s ^ rk));
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/pbe_ram.sv =====
// generic single port ram with registered read
`default_nettype none
module pbe_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata <= mem[addr];
            end
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/pbe_front.sv =====
// input stage: takes items, classifies them into commands and feeds the queue
`default_nettype none
module pbe_front (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    push,
    output logic                         full,
    input  wire logic                    operation,
    input  wire logic [4:0]              key_index,
    input  wire logic [63:0]             key_value,
    input  wire logic [63:0]             plaintext,
    input  wire pbe_pkg::q_status_t      q_status,
    output logic                         q_push,
    output pbe_pkg::cmd_t                q_cmd
);
    import pbe_pkg::*;

    logic hold_valid_reg;
    logic hold_valid_next;
    cmd_t hold_cmd_reg;
    cmd_t hold_cmd_next;
    logic accept;

    assign q_push = hold_valid_reg && !q_status.full;
    assign full   = hold_valid_reg && q_status.full;
    assign accept = push && !full;
    assign q_cmd  = hold_cmd_reg;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        hold_cmd_next   = hold_cmd_reg;
        if (accept)
        begin
            hold_valid_next     = 1'b1;
            hold_cmd_next.op    = operation;
            hold_cmd_next.index = key_index;
            hold_cmd_next.data  = (operation == OP_LOAD) ? key_value : plaintext;
        end
        else if (q_push)
        begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_cmd_reg <= hold_cmd_next;
    end

endmodule
`default_nettype wire

// ===== hw/rtl/pbe_queue.sv =====
// short command queue between front and back
`default_nettype none
module pbe_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                wr,
    input  wire pbe_pkg::cmd_t       wr_cmd,
    input  wire logic                rd,
    output pbe_pkg::cmd_t            rd_cmd,
    output pbe_pkg::q_status_t       status
);
    import pbe_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign rd_cmd       = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = rd ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (wr && !rd)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (rd && !wr)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/pbe_back.sv =====
// execution engine: key store writes, round loop and result register
`default_nettype none
module pbe_back #(
    parameter int ROUNDS = pbe_pkg::ROUNDS_DEFAULT
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire pbe_pkg::q_status_t  q_status,
    input  wire pbe_pkg::cmd_t       head,
    output pbe_pkg::bk_ctrl_t        ctrl,
    input  wire logic                pop,
    output logic                     empty,
    output logic [63:0]              ciphertext
);
    import pbe_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_FINAL = 2'd2;

    logic [1:0]        fsm_reg;
    logic [1:0]        fsm_next;
    logic [KEY_AW-1:0] round_reg;
    logic [KEY_AW-1:0] round_next;
    block_t            state_reg;
    block_t            state_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    block_t            out_reg;
    block_t            out_next;

    logic              ram_en;
    logic              ram_we;
    logic [KEY_AW-1:0] ram_addr;
    block_t            ram_rdata;

    pbe_ram #(
        .WIDTH (BLOCK_W),
        .DEPTH (KEY_DEPTH)
    ) u_key_ram (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (head.data),
        .rdata (ram_rdata)
    );

    assign empty      = !out_valid_reg;
    assign ciphertext = out_reg;

    always_comb
    begin
        fsm_next       = fsm_reg;
        round_next     = round_reg;
        state_next     = state_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        ram_en         = 1'b0;
        ram_we         = 1'b0;
        ram_addr       = head.index;
        ctrl.pop       = 1'b0;
        ctrl.busy      = (fsm_reg != ST_IDLE);

        if (pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end

        case (fsm_reg)
            ST_IDLE:
            begin
                if (!q_status.empty)
                begin
                    ctrl.pop = 1'b1;
                    ram_en   = 1'b1;
                    if (head.op == OP_LOAD)
                    begin
                        ram_we = 1'b1;
                    end
                    else
                    begin
                        // fetch key 0 while the plaintext is latched
                        ram_addr   = '0;
                        state_next = head.data;
                        round_next = '0;
                        fsm_next   = ST_RUN;
                    end
                end
            end
            ST_RUN:
            begin
                state_next = round_fn(state_reg, ram_rdata);
                ram_en     = 1'b1;
                ram_addr   = round_reg + KEY_AW'(1);
                if (round_reg == KEY_AW'(ROUNDS - 1))
                begin
                    fsm_next = ST_FINAL;
                end
                else
                begin
                    round_next = round_reg + KEY_AW'(1);
                end
            end
            ST_FINAL:
            begin
                // final whitening key waits on the ram output until the result slot frees
                if (!out_valid_reg || pop)
                begin
                    out_next       = state_reg ^ ram_rdata;
                    out_valid_next = 1'b1;
                    round_next     = '0;
                    fsm_next       = ST_IDLE;
                end
            end
            default:
            begin
                fsm_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg       <= ST_IDLE;
            round_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fsm_reg       <= fsm_next;
            round_reg     <= round_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        state_reg <= state_next;
        out_reg   <= out_next;
    end

endmodule
`default_nettype wire

// ===== hw/rtl/present_block_encrypt.sv =====
// top level of the present-64 block encryption unit with a loadable round key store
// path: an item passes the input register, then the command queue, to the engine;
//   a key load is then written, an encrypt runs the round loop and the final whitening
// sharing: encrypts run one at a time, as the round loop reuses one round unit
//   and one key store port; loads drain at one per cycle while the engine is idle
// reset: asynchronous, clears queue, engine state and the result slot; key store is not
//   cleared and an entry holds no defined value until it is loaded
`default_nettype none
module present_block_encrypt #(
    parameter int ROUNDS = pbe_pkg::ROUNDS_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // item side, queue style: transfer when push and not full
    input  wire logic        push,
    output logic             full,
    input  wire logic        operation,
    input  wire logic [4:0]  key_index,
    input  wire logic [63:0] key_value,
    input  wire logic [63:0] plaintext,
    // result side, queue style: transfer when pop and not empty
    output logic             empty,
    input  wire logic        pop,
    output logic [63:0]      ciphertext
);
    import pbe_pkg::*;

    logic      q_push;
    cmd_t      q_wr_cmd;
    cmd_t      q_head;
    q_status_t q_status;
    bk_ctrl_t  bk_ctrl;

    // front: holding register that packs a transfer into a command
    pbe_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .operation (operation),
        .key_index (key_index),
        .key_value (key_value),
        .plaintext (plaintext),
        .q_status  (q_status),
        .q_push    (q_push),
        .q_cmd     (q_wr_cmd)
    );

    // in-order queue keeps loads and encrypts in arrival order, so a load
    // never touches keys that an earlier encrypt still reads
    pbe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (q_push),
        .wr_cmd (q_wr_cmd),
        .rd     (bk_ctrl.pop),
        .rd_cmd (q_head),
        .status (q_status)
    );

    // back: key store, one round per cycle, result slot
    pbe_back #(
        .ROUNDS (ROUNDS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_status   (q_status),
        .head       (q_head),
        .ctrl       (bk_ctrl),
        .pop        (pop),
        .empty      (empty),
        .ciphertext (ciphertext)
    );

    // the engine never takes a command from an empty queue
    a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        bk_ctrl.pop |-> !q_status.empty)
        else $error("engine popped an empty command queue");

    // the front never writes into a full queue
    a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_status.full)
        else $error("front wrote a full command queue");

    // while a block is in the round loop, no further command is taken
    a_busy_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
        bk_ctrl.busy |-> !bk_ctrl.pop)
        else $error("command taken while the engine was busy");

    // a command taken while idle shows the engine busy next cycle only for an encrypt
    a_encrypt_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (bk_ctrl.pop && q_head.op == OP_ENCRYPT) |=> bk_ctrl.busy)
        else $error("encrypt command did not start the round loop");

endmodule
`default_nettype wire

// ===== tb/present_encrypt_checker.sv =====
// checker for present_block_encrypt: tracks loaded round keys, predicts ciphertexts, compares
`timescale 1ns / 100ps
module present_encrypt_checker #(
    parameter int ROUNDS = pbe_pkg::ROUNDS_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  logic                full,
    input  logic                operation,
    input  logic [4:0]          key_index,
    input  pbe_pkg::block_t     key_value,
    input  pbe_pkg::block_t     plaintext,
    input  logic                empty,
    input  logic                pop,
    input  pbe_pkg::block_t     ciphertext,
    output int                  pending,
    output int                  mismatches
);
    import pbe_pkg::*;

    // nibble n of this word is the s-box output for input n
    localparam logic [63:0] SBOX_TABLE = 64'h2174_8FE3_DA09_B65C;

    typedef struct {
        block_t plain;
        block_t cipher;
    } block_pair_t;

    block_t      round_keys [KEY_DEPTH];
    block_pair_t ciphertext_due [$];

    initial mismatches = 0;

    task automatic report_mismatch(input string msg);
        if (mismatches < 100)
        begin
            $display("[%0t] %s", $time, msg);
        end
        mismatches++;
    endtask

    function automatic block_t substitute(input block_t s);
        block_t r;
        for (int n = 0; n < 16; n++)
        begin
            r[4*n +: 4] = SBOX_TABLE[4*s[4*n +: 4] +: 4];
        end
        return r;
    endfunction

    function automatic block_t permute_bits(input block_t s);
        block_t r;
        for (int i = 0; i < 63; i++)
        begin
            r[(16 * i) % 63] = s[i];
        end
        r[63] = s[63];
        return r;
    endfunction

    function automatic block_t present_encrypt(input block_t plain);
        block_t s;
        s = plain;
        for (int r = 0; r < ROUNDS; r++)
        begin
            s = permute_bits(substitute(s ^ round_keys[r]));
        end
        return s ^ round_keys[ROUNDS % KEY_DEPTH];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        block_pair_t head;
        if (!rst_n)
        begin
            ciphertext_due.delete();
            pending <= 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (ciphertext_due.size() == 0)
                begin
                    report_mismatch($sformatf("ciphertext %h with no encrypt waiting",
                                              ciphertext));
                end
                else
                begin
                    head = ciphertext_due.pop_front();
                    if (ciphertext !== head.cipher)
                    begin
                        report_mismatch($sformatf("plaintext %h: ciphertext %h, want %h",
                                                  head.plain, ciphertext, head.cipher));
                    end
                end
            end
            if (push && !full)
            begin
                if (operation == OP_LOAD)
                begin
                    round_keys[key_index] = key_value;
                end
                else
                begin
                    ciphertext_due.push_back('{plain: plaintext,
                                               cipher: present_encrypt(plaintext)});
                end
            end
            pending <= ciphertext_due.size();
        end
    end

endmodule

// ===== tb/tb_present_block_encrypt.sv =====
// testbench top for present_block_encrypt: clock, reset, item and pop stimulus, verdict
`timescale 1ns / 100ps
module tb_present_block_encrypt;
    import pbe_pkg::*;

    localparam int RANDOM_ITEMS = 1750;
    // hard stop, several times the slowest legal run
    localparam int CYCLE_LIMIT  = 1000000;
    // queue entry plus input register plus the round loop, with margin
    localparam int DRAIN_CYCLES = ROUNDS_DEFAULT + 16;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic        operation;
    logic [4:0]  key_index;
    block_t      key_value;
    block_t      plaintext;
    logic        empty;
    logic        pop = 1'b0;
    block_t      ciphertext;

    int          pending;
    int          mismatches;
    int          cycle_count;
    int          burst_left;

    // receiver stall pattern: a mode held for a random stretch of cycles
    int          stall_mode;
    int          stall_timer;

    present_block_encrypt u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .operation  (operation),
        .key_index  (key_index),
        .key_value  (key_value),
        .plaintext  (plaintext),
        .empty      (empty),
        .pop        (pop),
        .ciphertext (ciphertext)
    );

    present_encrypt_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .operation  (operation),
        .key_index  (key_index),
        .key_value  (key_value),
        .plaintext  (plaintext),
        .empty      (empty),
        .pop        (pop),
        .ciphertext (ciphertext),
        .pending    (pending),
        .mismatches (mismatches)
    );

    // 20 ns clock
    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // cycle counter watchdog, fires only if the run hangs
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("present_block_encrypt: mismatch");
        $finish;
    end

    // pop side: always pop, coin flip, rare pop, or a pop when the low five timer bits are zero
    initial
    begin
        stall_mode  = 0;
        stall_timer = 0;
    end

    always @(posedge clk)
    begin
        if (stall_timer == 0)
        begin
            stall_mode  = $urandom_range(0, 3);
            stall_timer = $urandom_range(50, 400);
        end
        else
        begin
            stall_timer--;
        end
        case (stall_mode)
            0:       pop <= 1'b1;
            1:       pop <= $urandom_range(0, 1);
            2:       pop <= ($urandom_range(0, 7) == 0);
            default: pop <= (stall_timer[4:0] == 5'd0);
        endcase
    end

    // mostly full random words, with all zeros, all ones and half words mixed in
    function automatic block_t rand_block();
        case ($urandom_range(0, 11))
            0:       return '0;
            1:       return '1;
            2:       return {32'h0, $urandom};
            3:       return {$urandom, 32'h0};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // one transfer on the item side, then the burst bookkeeping; a gap between
    // bursts is sometimes long enough for the round loop to go idle
    task automatic send_item(input logic op, input logic [4:0] idx,
                             input block_t key, input block_t plain);
        int gap;
        push      <= 1'b1;
        operation <= op;
        key_index <= idx;
        key_value <= key;
        plaintext <= plain;
        do
        begin
            @(posedge clk);
        end
        while (full);
        burst_left--;
        if (burst_left <= 0)
        begin
            case ($urandom_range(0, 7))
                0, 1:    gap = 0;
                2:       gap = $urandom_range(20, 60);
                default: gap = $urandom_range(1, 5);
            endcase
            if (gap > 0)
            begin
                push <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
    endtask

    task automatic load_key(input logic [4:0] idx, input block_t key);
        send_item(OP_LOAD, idx, key, rand_block());
    endtask

    task automatic encrypt_block(input block_t plain);
        send_item(OP_ENCRYPT, 5'($urandom), rand_block(), plain);
    endtask

    initial
    begin
        rst_n      = 1'b0;
        push       = 1'b0;
        operation  = OP_LOAD;
        key_index  = '0;
        key_value  = '0;
        plaintext  = '0;
        burst_left = 1;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill the whole key store first, an encrypt reads every entry
        for (int i = 0; i < KEY_DEPTH; i++)
        begin
            load_key(5'(i), rand_block());
        end

        // directed: extreme plaintexts
        encrypt_block('0);
        encrypt_block('1);
        encrypt_block(64'h5555_5555_5555_5555);
        encrypt_block(64'hAAAA_AAAA_AAAA_AAAA);
        // extreme key values at the first and last entry, ignored plaintext all ones, then all zeros
        send_item(OP_LOAD, 5'd0, '0, '1);
        send_item(OP_LOAD, 5'd31, '1, '0);
        encrypt_block(64'h0123_4567_89AB_CDEF);
        // repeated loads to the last and the first entry, the later value wins
        load_key(5'd31, 64'h0F0F_0F0F_F0F0_F0F0);
        load_key(5'd31, '0);
        load_key(5'd0, '1);
        load_key(5'd0, 64'h8000_0000_0000_0001);
        encrypt_block(64'hFEDC_BA98_7654_3210);
        // ignored key fields at their extremes on encrypts
        send_item(OP_ENCRYPT, 5'd31, '1, 64'h8000_0000_0000_0000);
        send_item(OP_ENCRYPT, 5'd0, '0, 64'h0000_0000_0000_0001);
        // a middle entry reloaded right behind an encrypt in flight
        encrypt_block(64'hDEAD_BEEF_0000_FFFF);
        load_key(5'd15, '1);
        encrypt_block(64'hDEAD_BEEF_0000_FFFF);

        // random part: every encrypt is legal now, so mix loads and encrypts freely
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if ($urandom_range(0, 99) < 45)
            begin
                encrypt_block(rand_block());
            end
            else
            begin
                load_key(5'($urandom), rand_block());
            end
        end

        // one more edge so the checker has counted the last transfer
        push <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
        begin
            $display("present_block_encrypt: match");
        end
        else
        begin
            $display("present_block_encrypt: mismatch");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/pbe_pkg.sv
hw/rtl/pbe_ram.sv
hw/rtl/pbe_front.sv
hw/rtl/pbe_queue.sv
hw/rtl/pbe_back.sv
hw/rtl/present_block_encrypt.sv
tb/present_encrypt_checker.sv
tb/tb_present_block_encrypt.sv
